// ----- hw/rtl/nmea_rmc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC parser package
// Shared widths, character codes, record types and constant tables.
// ----------------------------------------------------------------------------
package nmea_rmc_pkg;

  localparam int FRAC_DIGITS_DEF = 5;

  localparam int WHOLE_W   = 17;
  localparam int FRAC_W    = 24;
  localparam int CNT_W     = 3;
  localparam int DEG_W     = 10;
  localparam int LAT_OUT_W = 27;
  localparam int LON_OUT_W = 30;
  localparam int RES_W     = 30;

  localparam int QUEUE_DEPTH = 4;
  localparam int PIPE_STAGES = 5;

  localparam logic [CNT_W-1:0] LAT_WHOLE_MAX = 3'd4;
  localparam logic [CNT_W-1:0] LON_WHOLE_MAX = 3'd5;
  localparam logic [2:0]       HDR_LAST      = 3'd5;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;

  // Division of the whole part by 100 through a reciprocal multiply.
  localparam int     DIV100_SHIFT = WHOLE_W + 7;
  localparam longint DIV100_RECIP = ((longint'(1) << DIV100_SHIFT) + 99) / 100;

  localparam longint MICRO = 1000000;

  typedef struct packed {
    logic [WHOLE_W-1:0] whole;
    logic [FRAC_W-1:0]  frac;
    logic [CNT_W-1:0]   frac_count;
  } coord_t;

  typedef struct packed {
    coord_t lat;
    coord_t lon;
    logic   bad;
  } line_rec_t;

  function automatic logic [FRAC_W-1:0] pow10(input logic [CNT_W-1:0] n);
    logic [FRAC_W-1:0] r;
    unique case (n)
      3'd0:    r = FRAC_W'(1);
      3'd1:    r = FRAC_W'(10);
      3'd2:    r = FRAC_W'(100);
      3'd3:    r = FRAC_W'(1000);
      3'd4:    r = FRAC_W'(10000);
      3'd5:    r = FRAC_W'(100000);
      3'd6:    r = FRAC_W'(1000000);
      default: r = FRAC_W'(10000000);
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = CH_DOLLAR;
      3'd1:    c = CH_G;
      3'd2:    c = CH_P;
      3'd3:    c = CH_R;
      3'd4:    c = CH_M;
      3'd5:    c = CH_C;
      default: c = CH_DOLLAR;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/nmea_rmc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC parser channel interfaces
// Byte input channel and position result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface nmea_rmc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nmea_rmc_pos_if;
  import nmea_rmc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [LAT_OUT_W-1:0] lat_microdeg;
  logic [LON_OUT_W-1:0] lon_microdeg;
  logic                 number_error;

  modport source (output valid, output lat_microdeg, output lon_microdeg,
                  output number_error, input ready);
  modport sink   (input valid, input lat_microdeg, input lon_microdeg,
                  input number_error, output ready);
endinterface

// ----- hw/rtl/nmea_rmc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC front end
// Matches the sentence header, counts fields and accumulates the two
// coordinates; pushes one record into the queue per completed sentence.
// ----------------------------------------------------------------------------
module nmea_rmc_front #(
  parameter int FRAC_DIGITS = nmea_rmc_pkg::FRAC_DIGITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  nmea_rmc_byte_if.sink           in_byte,
  input  logic                    rec_full,
  output logic                    rec_push,
  output nmea_rmc_pkg::line_rec_t rec_data
);
  import nmea_rmc_pkg::*;

  localparam logic [CNT_W-1:0] FRAC_MAX      = CNT_W'(FRAC_DIGITS);
  localparam logic [3:0]       COMMA_STATUS  = 4'd2;
  localparam logic [3:0]       COMMA_LAT     = 4'd3;
  localparam logic [3:0]       COMMA_LON     = 4'd5;
  localparam logic [3:0]       COMMA_SAT     = 4'd15;

  typedef struct packed {
    logic [WHOLE_W-1:0] whole;
    logic [FRAC_W-1:0]  frac;
    logic [CNT_W-1:0]   whole_count;
    logic [CNT_W-1:0]   frac_count;
    logic               dot_seen;
  } acc_t;

  typedef struct packed {
    acc_t acc;
    logic err;
  } feed_t;

  function automatic feed_t feed(input acc_t a, input logic [7:0] ch,
                                 input logic [CNT_W-1:0] whole_max);
    feed_t      r;
    logic [3:0] d;
    r     = '{acc: a, err: 1'b0};
    d     = ch[3:0];
    if (ch == CH_DOT) begin
      if (a.dot_seen) r.err = 1'b1;
      else r.acc.dot_seen = 1'b1;
    end else if (ch >= CH_0 && ch <= CH_9) begin
      if (!a.dot_seen) begin
        if (a.whole_count < whole_max) begin
          r.acc.whole       = a.whole * WHOLE_W'(10) + WHOLE_W'(d);
          r.acc.whole_count = a.whole_count + CNT_W'(1);
        end else begin
          r.err = 1'b1;
        end
      end else begin
        if (a.frac_count < FRAC_MAX) begin
          r.acc.frac       = a.frac * FRAC_W'(10) + FRAC_W'(d);
          r.acc.frac_count = a.frac_count + CNT_W'(1);
        end else begin
          r.err = 1'b1;
        end
      end
    end
    return r;
  endfunction

  logic [2:0] hdr_pos_r, hdr_pos_nxt;
  logic       matched_r, matched_nxt;
  logic       skip_r, skip_nxt;
  logic [3:0] comma_r, comma_nxt;
  acc_t       lat_r, lat_nxt;
  acc_t       lon_r, lon_nxt;
  logic       bad_r, bad_nxt;

  logic       accept;
  logic       clear;
  logic [7:0] ch;
  feed_t      lat_feed;
  feed_t      lon_feed;

  assign in_byte.ready = !rec_full;
  assign accept        = in_byte.valid && in_byte.ready;
  assign ch            = in_byte.rx_byte;

  assign rec_data.lat = '{whole: lat_r.whole, frac: lat_r.frac,
                          frac_count: lat_r.frac_count};
  assign rec_data.lon = '{whole: lon_r.whole, frac: lon_r.frac,
                          frac_count: lon_r.frac_count};
  assign rec_data.bad = bad_r;

  always_comb begin
    hdr_pos_nxt = hdr_pos_r;
    matched_nxt = matched_r;
    skip_nxt    = skip_r;
    comma_nxt   = comma_r;
    lat_nxt     = lat_r;
    lon_nxt     = lon_r;
    bad_nxt     = bad_r;
    rec_push    = 1'b0;
    clear       = 1'b0;
    lat_feed    = feed(lat_r, ch, LAT_WHOLE_MAX);
    lon_feed    = feed(lon_r, ch, LON_WHOLE_MAX);

    if (accept) begin
      if (skip_r) begin
        if (ch == CH_NL) clear = 1'b1;
      end else if (!matched_r) begin
        if (ch == hdr_char(hdr_pos_r)) begin
          hdr_pos_nxt = hdr_pos_r + 3'd1;
          if (hdr_pos_r == HDR_LAST) matched_nxt = 1'b1;
        end else if (ch == CH_NL) begin
          clear = 1'b1;
        end else begin
          skip_nxt = 1'b1;
        end
      end else if (ch == CH_NL) begin
        rec_push = 1'b1;
        clear    = 1'b1;
      end else if (ch == CH_COMMA) begin
        if (comma_r != COMMA_SAT) comma_nxt = comma_r + 4'd1;
      end else if (comma_r == COMMA_STATUS) begin
        if (ch == CH_V) skip_nxt = 1'b1;
      end else if (comma_r == COMMA_LAT) begin
        lat_nxt = lat_feed.acc;
        bad_nxt = bad_r | lat_feed.err;
      end else if (comma_r == COMMA_LON) begin
        lon_nxt = lon_feed.acc;
        bad_nxt = bad_r | lon_feed.err;
      end
    end

    // Every newline starts a fresh line.
    if (clear) begin
      hdr_pos_nxt = '0;
      matched_nxt = 1'b0;
      skip_nxt    = 1'b0;
      comma_nxt   = '0;
      lat_nxt     = '0;
      lon_nxt     = '0;
      bad_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r <= '0;
      matched_r <= 1'b0;
      skip_r    <= 1'b0;
      comma_r   <= '0;
      lat_r     <= '0;
      lon_r     <= '0;
      bad_r     <= 1'b0;
    end else begin
      hdr_pos_r <= hdr_pos_nxt;
      matched_r <= matched_nxt;
      skip_r    <= skip_nxt;
      comma_r   <= comma_nxt;
      lat_r     <= lat_nxt;
      lon_r     <= lon_nxt;
      bad_r     <= bad_nxt;
    end
  end

endmodule

// ----- hw/rtl/nmea_rmc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC record queue
// Small show-ahead FIFO of sentence records between front and back end.
// ----------------------------------------------------------------------------
module nmea_rmc_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  nmea_rmc_pkg::line_rec_t push_data,
  output logic                    full,
  input  logic                    pop,
  output logic                    head_valid,
  output nmea_rmc_pkg::line_rec_t head_data
);
  import nmea_rmc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  line_rec_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]    count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full       = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) count_nxt = count_r + (PTR_W+1)'(1);
    else if (!do_push && do_pop) count_nxt = count_r - (PTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- hw/rtl/nmea_rmc_conv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC coordinate converter
// Five-stage pipeline turning ddmm.f into whole microdegrees, truncated.
// ----------------------------------------------------------------------------
module nmea_rmc_conv #(
  parameter int FRAC_DIGITS = nmea_rmc_pkg::FRAC_DIGITS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  nmea_rmc_pkg::coord_t              coord_in,
  output logic [nmea_rmc_pkg::RES_W-1:0]    microdeg
);
  import nmea_rmc_pkg::*;

  // q = floor(minutes_scaled * 10^6 / (60 * 10^F)) = floor(X / D), where
  // X = minutes_scaled * M is below 10^9 for every allowed F.
  localparam int X_W     = 30;
  localparam int REM_W   = 7;
  localparam int Q_W     = 21;
  localparam int RECIP_W = X_W + 2;
  localparam int PROD_W  = X_W + RECIP_W;
  localparam int P100_W  = 2 * WHOLE_W + 1;

  localparam logic [CNT_W-1:0] FRAC_CNT = CNT_W'(FRAC_DIGITS);
  localparam longint SCALE  = longint'(pow10(FRAC_CNT));
  localparam longint MUL_M  =
    longint'(pow10(CNT_W'((FRAC_DIGITS <= 5) ? 5 - FRAC_DIGITS : 0)));
  localparam longint DIV_D  =
    6 * longint'(pow10(CNT_W'((FRAC_DIGITS > 5) ? FRAC_DIGITS - 5 : 0)));
  localparam int     DIV_L  = $clog2(DIV_D);
  localparam int     SHIFT  = X_W + DIV_L;
  localparam longint RECIP_L = ((longint'(1) << SHIFT) + DIV_D - 1) / DIV_D;

  localparam logic [X_W-1:0]     K_REM = X_W'(SCALE * MUL_M);
  localparam logic [X_W-1:0]     K_FRAC = X_W'(MUL_M);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  // Stage 1: whole / 100
  logic [WHOLE_W-1:0] whole_s1_r;
  logic [FRAC_W-1:0]  frac_s1_r;
  logic [CNT_W-1:0]   cnt_s1_r;
  logic [DEG_W-1:0]   deg_s1_r;
  // Stage 2: whole % 100 and padded fraction
  logic [REM_W-1:0]   rem_s2_r;
  logic [FRAC_W-1:0]  fs_s2_r;
  logic [DEG_W-1:0]   deg_s2_r;
  // Stage 3: scaled minutes
  logic [X_W-1:0]     x_s3_r;
  logic [DEG_W-1:0]   deg_s3_r;
  // Stage 4: reciprocal product
  logic [PROD_W-1:0]  prod_s4_r;
  logic [DEG_W-1:0]   deg_s4_r;
  // Stage 5: result
  logic [RES_W-1:0]   res_s5_r;

  logic [P100_W-1:0]  p100;
  logic [CNT_W-1:0]   pad;

  assign p100 = P100_W'(coord_in.whole) * P100_W'(DIV100_RECIP);
  assign pad  = FRAC_CNT - cnt_s1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      whole_s1_r <= coord_in.whole;
      frac_s1_r  <= coord_in.frac;
      cnt_s1_r   <= coord_in.frac_count;
      deg_s1_r   <= DEG_W'(p100 >> DIV100_SHIFT);

      rem_s2_r   <= REM_W'(whole_s1_r - WHOLE_W'(deg_s1_r) * WHOLE_W'(100));
      fs_s2_r    <= frac_s1_r * pow10(pad);
      deg_s2_r   <= deg_s1_r;

      x_s3_r     <= X_W'(rem_s2_r) * K_REM + X_W'(fs_s2_r) * K_FRAC;
      deg_s3_r   <= deg_s2_r;

      prod_s4_r  <= PROD_W'(x_s3_r) * PROD_W'(RECIP);
      deg_s4_r   <= deg_s3_r;

      res_s5_r   <= RES_W'(deg_s4_r) * RES_W'(MICRO) + RES_W'(prod_s4_r[SHIFT +: Q_W]);
    end
  end

  assign microdeg = res_s5_r;

endmodule

// ----- hw/rtl/nmea_rmc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC back end
// Pops sentence records, converts both coordinates and holds the result
// in the last pipeline stage until the receiver takes it.
// ----------------------------------------------------------------------------
module nmea_rmc_back #(
  parameter int FRAC_DIGITS = nmea_rmc_pkg::FRAC_DIGITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    head_valid,
  input  nmea_rmc_pkg::line_rec_t head_data,
  output logic                    pop,
  nmea_rmc_pos_if.source          out_pos
);
  import nmea_rmc_pkg::*;

  logic [PIPE_STAGES-1:0] valid_r, valid_nxt;
  logic [PIPE_STAGES-1:0] err_r;
  logic                   en;
  logic [RES_W-1:0]       lat_res;
  logic [RES_W-1:0]       lon_res;

  // The whole pipeline moves unless a finished result is stalled at the end.
  assign en        = !valid_r[PIPE_STAGES-1] || out_pos.ready;
  assign pop       = en && head_valid;
  assign valid_nxt = en ? {valid_r[PIPE_STAGES-2:0], head_valid} : valid_r;

  nmea_rmc_conv #(.FRAC_DIGITS(FRAC_DIGITS)) u_lat (
    .clk      (clk),
    .en       (en),
    .coord_in (head_data.lat),
    .microdeg (lat_res)
  );

  nmea_rmc_conv #(.FRAC_DIGITS(FRAC_DIGITS)) u_lon (
    .clk      (clk),
    .en       (en),
    .coord_in (head_data.lon),
    .microdeg (lon_res)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      err_r <= {err_r[PIPE_STAGES-2:0], head_data.bad};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign out_pos.valid        = valid_r[PIPE_STAGES-1];
  assign out_pos.lat_microdeg = lat_res[LAT_OUT_W-1:0];
  assign out_pos.lon_microdeg = lon_res[LON_OUT_W-1:0];
  assign out_pos.number_error = err_r[PIPE_STAGES-1];

endmodule

// ----- hw/rtl/nmea_rmc_position_parser_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC position parser
// Parses $GPRMC sentences from a byte stream and reports the position.
// ----------------------------------------------------------------------------
// Usage:
//   in_byte takes one received character per request; it is ready whenever
//   the record queue has room, so bytes stream in at one per cycle.
//   out_pos delivers one request per valid $GPRMC sentence, at its newline:
//   latitude and longitude magnitudes in microdegrees and an error flag for
//   coordinate fields with too many digits or a second dot.
//   Latitude is the field after the third comma, longitude after the fifth.
//   A sentence with V in the status field, or a line with another header,
//   gives no result.
//   The result is registered through the queue and the five-stage converter
//   (divide by 100, remainder and padding, scale, reciprocal multiply,
//   combine). Bytes are taken one per cycle while the queue has room.
//   When out_pos stalls, the converter holds; up to 4 further sentences
//   wait in the queue, and in_byte drops ready only when that queue fills.
//   Reset (rst_n low, synchronous) empties queue and pipeline and starts
//   a new line.
// ----------------------------------------------------------------------------
module nmea_rmc_position_parser_unit #(
  parameter int FRAC_DIGITS = nmea_rmc_pkg::FRAC_DIGITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  nmea_rmc_byte_if.sink  in_byte,
  nmea_rmc_pos_if.source out_pos
);
  import nmea_rmc_pkg::*;

  logic      rec_push;
  logic      rec_full;
  line_rec_t rec_data;
  logic      head_valid;
  logic      rec_pop;
  line_rec_t head_data;

  nmea_rmc_front #(.FRAC_DIGITS(FRAC_DIGITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_byte  (in_byte),
    .rec_full (rec_full),
    .rec_push (rec_push),
    .rec_data (rec_data)
  );

  nmea_rmc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (rec_push),
    .push_data  (rec_data),
    .full       (rec_full),
    .pop        (rec_pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  nmea_rmc_back #(.FRAC_DIGITS(FRAC_DIGITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (rec_pop),
    .out_pos    (out_pos)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC position parser testbench
// Streams short directed lines and then random $GPRMC sentences, broken
// headers and byte noise into the parser. Each accepted byte goes through a
// local line parser that computes the expected position request. Every
// position request that the block delivers is checked field by field
// against the oldest expected one. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import nmea_rmc_pkg::*;

  localparam int    FRAC_DIGITS = FRAC_DIGITS_DEF;
  localparam string RMC_HEADER  = "$GPRMC";
  localparam int    LAT_DIGITS  = 4;
  localparam int    LON_DIGITS  = 5;
  localparam int    BYTE_TARGET = 1600;
  localparam int    FIX_TARGET  = 16;
  localparam int    DRAIN_LIMIT = 4000;
  localparam int    SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [16:0]       whole;
    logic [FRAC_W-1:0] frac;
    logic [2:0]        whole_cnt;
    logic [2:0]        frac_cnt;
    logic              dot_seen;
  } coord_acc_t;

  typedef struct packed {
    logic [2:0] hdr_pos;
    logic       matched;
    logic       skipping;
    logic [3:0] commas;
    coord_acc_t lat;
    coord_acc_t lon;
    logic       bad;
  } line_state_t;

  typedef struct packed {
    logic [LAT_OUT_W-1:0] lat;
    logic [LON_OUT_W-1:0] lon;
    logic                 err;
  } pos_fix_t;

  bit   clk;
  logic rst_n;

  nmea_rmc_byte_if byte_ch ();
  nmea_rmc_pos_if  pos_ch ();

  nmea_rmc_position_parser_unit #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_byte(byte_ch),
    .out_pos(pos_ch)
  );

  logic [7:0]  tx_bytes[$];
  pos_fix_t    expected_fixes[$];
  line_state_t line_st;
  logic        byte_taken;
  int          cyc;
  int          err_count;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned pow10_u64(input int n);
    longint unsigned r;
    r = 1;
    repeat (n) r = r * 10;
    return r;
  endfunction

  function automatic longint unsigned coord_to_microdeg(input coord_acc_t a);
    longint unsigned scale;
    longint unsigned degs;
    longint unsigned mins;
    int              pad;
    scale = pow10_u64(FRAC_DIGITS);
    pad   = (FRAC_DIGITS - int'(a.frac_cnt)) & 7;
    degs  = longint'(a.whole) / 100;
    mins  = (longint'(a.whole) % 100) * scale + longint'(a.frac) * pow10_u64(pad);
    return degs * 1000000 + (mins * 1000000) / (60 * scale);
  endfunction

  function automatic coord_acc_t feed_coord(input coord_acc_t a, input logic [7:0] ch,
                                            input int whole_max, inout logic bad);
    coord_acc_t n;
    n = a;
    if (ch == CH_DOT) begin
      if (n.dot_seen) bad = 1'b1;
      else n.dot_seen = 1'b1;
    end else if (ch >= CH_0 && ch <= CH_9) begin
      if (!n.dot_seen) begin
        if (n.whole_cnt < whole_max) begin
          n.whole     = 17'(n.whole * 10 + (ch - CH_0));
          n.whole_cnt = 3'(n.whole_cnt + 1);
        end else begin
          bad = 1'b1;
        end
      end else begin
        if (n.frac_cnt < FRAC_DIGITS) begin
          n.frac     = FRAC_W'(n.frac * 10 + (ch - CH_0));
          n.frac_cnt = 3'(n.frac_cnt + 1);
        end else begin
          bad = 1'b1;
        end
      end
    end
    return n;
  endfunction

  task automatic parse_byte(input logic [7:0] ch);
    pos_fix_t fix;
    logic     b;
    if (line_st.skipping) begin
      if (ch == CH_NL) line_st = '0;
    end else if (!line_st.matched) begin
      if (ch == RMC_HEADER[line_st.hdr_pos]) begin
        line_st.hdr_pos = 3'(line_st.hdr_pos + 1);
        if (line_st.hdr_pos == RMC_HEADER.len()) line_st.matched = 1'b1;
      end else if (ch == CH_NL) begin
        line_st = '0;
      end else begin
        line_st.skipping = 1'b1;
      end
    end else if (ch == CH_NL) begin
      fix.lat = LAT_OUT_W'(coord_to_microdeg(line_st.lat));
      fix.lon = LON_OUT_W'(coord_to_microdeg(line_st.lon));
      fix.err = line_st.bad;
      expected_fixes.push_back(fix);
      line_st = '0;
    end else if (ch == CH_COMMA) begin
      if (line_st.commas != 4'd15) line_st.commas = 4'(line_st.commas + 1);
    end else begin
      b = line_st.bad;
      case (line_st.commas)
        4'd2: if (ch == CH_V) line_st.skipping = 1'b1;
        4'd3: line_st.lat = feed_coord(line_st.lat, ch, LAT_DIGITS, b);
        4'd5: line_st.lon = feed_coord(line_st.lon, ch, LON_DIGITS, b);
        default: ;
      endcase
      line_st.bad = b;
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
  endtask

  // Style 1 gives all nines and style 2 all zeros, to hit the extremes.
  task automatic push_digits(input int n, input int style);
    for (int i = 0; i < n; i++) begin
      case (style)
        1:       tx_bytes.push_back(CH_9);
        2:       tx_bytes.push_back(CH_0);
        default: tx_bytes.push_back(CH_0 + 8'($urandom_range(0, 9)));
      endcase
    end
  endtask

  task automatic push_coord(input int whole_max);
    int    wc;
    int    fc;
    int    style;
    string junk;
    junk  = " -+\rNSW$";
    style = $urandom_range(0, 19);
    style = (style < 2) ? 1 : (style == 2) ? 2 : 0;
    wc = ($urandom_range(0, 9) < 7) ? whole_max : $urandom_range(0, whole_max + 1);
    fc = ($urandom_range(0, 9) < 7) ? FRAC_DIGITS : $urandom_range(0, FRAC_DIGITS + 2);
    push_digits(wc, style);
    if ($urandom_range(0, 9) != 0) begin
      tx_bytes.push_back(CH_DOT);
      push_digits(fc, style);
      if ($urandom_range(0, 19) == 0) begin
        tx_bytes.push_back(CH_DOT);
        push_digits(1, 0);
      end
    end
    if ($urandom_range(0, 9) == 0) tx_bytes.push_back(junk[$urandom_range(0, junk.len() - 1)]);
  endtask

  task automatic push_sentence(output bit reports);
    int r;
    reports = 1'b1;
    push_text(RMC_HEADER);
    // A matched sentence that stops before its coordinates still reports.
    if ($urandom_range(0, 11) == 0) begin
      if ($urandom_range(0, 1)) push_text("\n");
      else push_text(",,\n");
      return;
    end
    push_text(",");
    push_digits($urandom_range(0, 6), 0);
    if ($urandom_range(0, 1)) push_text(".00");
    push_text(",");
    r = $urandom_range(0, 9);
    if (r == 0) begin
      push_text("V");
      reports = 1'b0;
    end else if (r == 1) begin
      push_text("AV");
      reports = 1'b0;
    end else if (r != 2) begin
      push_text("A");
    end
    push_text(",");
    push_coord(LAT_DIGITS);
    if ($urandom_range(0, 1)) push_text(",N,");
    else push_text(",S,");
    push_coord(LON_DIGITS);
    if ($urandom_range(0, 1)) push_text(",E");
    else push_text(",W");
    if ($urandom_range(0, 6) == 0) begin
      // Enough trailing fields to saturate the comma count.
      repeat ($urandom_range(10, 14)) begin
        push_text(",");
        push_digits(1, 0);
      end
    end else begin
      push_text(",,,*6A\r");
    end
    push_text("\n");
  endtask

  task automatic push_broken_header();
    int         k;
    logic [7:0] c;
    k = $urandom_range(0, RMC_HEADER.len() - 1);
    for (int i = 0; i < k; i++) tx_bytes.push_back(RMC_HEADER[i]);
    do c = 8'($urandom_range(0, 255)); while (c == RMC_HEADER[k]);
    tx_bytes.push_back(c);
    if (c != CH_NL) begin
      repeat ($urandom_range(0, 12)) tx_bytes.push_back(8'($urandom_range(32, 126)));
      push_text("\n");
    end
  endtask

  task automatic build_stimulus();
    int r;
    int fixes;
    bit reports;
    fixes = 0;
    // Directed lines: empty line, mismatch skipped to its newline, byte
    // extremes, bare header, and a newline before the header completes.
    push_text("\n");
    push_text("$GX\n");
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    push_text("\n");
    push_text("$GPRMC\n");
    push_text("$GP\n");
    while (tx_bytes.size() < BYTE_TARGET || fixes < FIX_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        push_sentence(reports);
        if (reports) fixes++;
      end else if (r < 85) begin
        push_broken_header();
      end else begin
        repeat ($urandom_range(0, 24)) tx_bytes.push_back(8'($urandom_range(0, 255)));
        push_text("\n");
      end
    end
  endtask

  // ---------------------------------------------------------------- channels

  function automatic bit idle_now();
    if (cyc >= 1000 && cyc < 2500) return 1'b0;
    return $urandom_range(0, 99) < 31;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  always @(posedge clk) begin
    cyc        <= cyc + 1;
    byte_taken <= rst_n && byte_ch.valid && byte_ch.ready;
    if (!rst_n) begin
      line_st = '0;
    end else if (byte_ch.valid && byte_ch.ready) begin
      parse_byte(byte_ch.rx_byte);
    end
  end

  // A request that is still waiting for ready keeps its valid and byte.
  always @(negedge clk) begin
    if (!rst_n) begin
      byte_ch.valid <= 1'b0;
      pos_ch.ready  <= 1'b0;
    end else begin
      pos_ch.ready <= !idle_now();
      if (!byte_ch.valid || byte_taken) begin
        if (tx_bytes.size() > 0 && !idle_now()) begin
          byte_ch.valid   <= 1'b1;
          byte_ch.rx_byte <= tx_bytes.pop_front();
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    pos_fix_t want;
    if (rst_n && pos_ch.valid && pos_ch.ready) begin
      if (expected_fixes.size() == 0) begin
        report_mismatch($sformatf("unexpected position request lat=%0d lon=%0d err=%0d",
                                  pos_ch.lat_microdeg, pos_ch.lon_microdeg,
                                  pos_ch.number_error));
      end else begin
        want = expected_fixes.pop_front();
        if (pos_ch.lat_microdeg !== want.lat)
          report_mismatch($sformatf("lat_microdeg got %0d expected %0d",
                                    pos_ch.lat_microdeg, want.lat));
        if (pos_ch.lon_microdeg !== want.lon)
          report_mismatch($sformatf("lon_microdeg got %0d expected %0d",
                                    pos_ch.lon_microdeg, want.lon));
        if (pos_ch.number_error !== want.err)
          report_mismatch($sformatf("number_error got %0d expected %0d",
                                    pos_ch.number_error, want.err));
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int waited;
    rst_n           = 1'b0;
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = '0;
    pos_ch.ready    = 1'b0;
    line_st         = '0;
    byte_taken      = 1'b0;
    cyc             = 0;
    err_count       = 0;
    build_stimulus();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    while (tx_bytes.size() > 0 || byte_ch.valid) @(posedge clk);
    waited = 0;
    while (expected_fixes.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_fixes.size() > 0)
      report_mismatch($sformatf("%0d position requests never arrived",
                                expected_fixes.size()));
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
